// File: src/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define BFFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is low.
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BFFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/bffa_pkg.sv
// Types and constants of the bitmap first-fit allocator.
`default_nettype none
package bffa_pkg;
    localparam int NUM_UNITS = 4096;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = NUM_UNITS / WORD_W;
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int UNIT_W    = 12;
    localparam int SIZE_W    = 13;
    localparam int TYPE_W    = 2;
    localparam int STAT_W    = 2;

    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADSIZE = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_CLEAR,
        OP_REPLY
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [STAT_W-1:0]   status;
        logic [UNIT_W-1:0]   offset;
        logic [SIZE_W-1:0]   size;
    } t_cmd;
endpackage
`default_nettype wire

// File: src/bitmap_first_fit_allocator_unit.sv
// Top level of the bitmap first-fit contiguous allocator.
//
//  channel  direction  handshake                 payload
//  request  in         i_in_valid / o_in_ready   i_req_type, i_unit_offset, i_req_size
//  result   out        o_out_valid / i_out_ready o_status, o_unit_start
//
// An allocate scans the 32-bit map words one at a time (read, evaluate), up
// to 128 words for a full 4096-unit scan, then marks each word of the run
// (read, write); the single map RAM port forces these steps. Free marks each
// word it touches the same way; clear and rejected items skip the RAM. Reset
// and clear empty the map at once through per-word valid flags. A two-entry
// queue keeps taking items while the back end works or the result waits.
`default_nettype none
`include "assert_macros.svh"
module bitmap_first_fit_allocator_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [bffa_pkg::TYPE_W-1:0] i_req_type,
    input  wire logic [bffa_pkg::UNIT_W-1:0] i_unit_offset,
    input  wire logic [bffa_pkg::SIZE_W-1:0] i_req_size,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [bffa_pkg::STAT_W-1:0]      o_status,
    output logic [bffa_pkg::UNIT_W-1:0]      o_unit_start
);
    logic           w_cmd_valid;
    logic           w_cmd_pop;
    bffa_pkg::t_cmd w_cmd;

    // Classify each item and hold it until the back end is free.
    bffa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_unit_offset (i_unit_offset),
        .i_req_size    (i_req_size),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    // Scan, mark and report.
    bffa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_unit_start (o_unit_start)
    );

    // Only a successful allocate carries a start unit.
    `BFFA_ASSERT_IMPLY(a_start_zero, i_clk, i_rst_n, o_out_valid && o_status != bffa_pkg::ST_OK, o_unit_start == '0)
    // Never pop an empty queue.
    `BFFA_ASSERT_IMPLY(a_pop_has_cmd, i_clk, i_rst_n, w_cmd_pop, w_cmd_valid)
    // A popped command cannot produce a result in the very next cycle.
    `BFFA_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, w_cmd_pop && !o_out_valid, !o_out_valid)
endmodule
`default_nettype wire

// File: src/bffa_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: src/bffa_front.sv
// Front end: accept items, check sizes and ranges, queue commands.
`default_nettype none
module bffa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [bffa_pkg::TYPE_W-1:0]   i_req_type,
    input  wire logic [bffa_pkg::UNIT_W-1:0]   i_unit_offset,
    input  wire logic [bffa_pkg::SIZE_W-1:0]   i_req_size,
    output logic                               o_cmd_valid,
    output bffa_pkg::t_cmd                     o_cmd,
    input  wire logic                          i_cmd_pop
);
    bffa_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    bffa_pkg::t_cmd w_cmd;
    logic [bffa_pkg::SIZE_W:0] w_reach;
    logic           w_push;

    always_comb begin
        w_reach = {2'b00, i_unit_offset} + {1'b0, i_req_size};
        w_cmd.offset = i_unit_offset;
        w_cmd.size   = i_req_size;
        w_cmd.status = bffa_pkg::ST_OK;
        w_cmd.op     = bffa_pkg::OP_REPLY;
        unique case (i_req_type)
            bffa_pkg::REQ_ALLOC: begin
                if (i_req_size == '0) begin
                    w_cmd.status = bffa_pkg::ST_BADSIZE;
                end else begin
                    w_cmd.op = bffa_pkg::OP_ALLOC;
                end
            end
            bffa_pkg::REQ_FREE: begin
                if (i_req_size == '0) begin
                    w_cmd.status = bffa_pkg::ST_BADSIZE;
                end else if (w_reach > (bffa_pkg::SIZE_W+1)'(bffa_pkg::NUM_UNITS)) begin
                    w_cmd.status = bffa_pkg::ST_RANGE;
                end else begin
                    w_cmd.op = bffa_pkg::OP_FREE;
                end
            end
            bffa_pkg::REQ_CLEAR: w_cmd.op = bffa_pkg::OP_CLEAR;
            default:             w_cmd.op = bffa_pkg::OP_REPLY;
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

// File: src/bffa_back.sv
// Back end: scan the bitmap word by word, mark runs, deliver results.
`default_nettype none
module bffa_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    input  wire bffa_pkg::t_cmd              i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [bffa_pkg::STAT_W-1:0]      o_status,
    output logic [bffa_pkg::UNIT_W-1:0]      o_unit_start
);
    localparam int WW = bffa_pkg::WORD_W;
    localparam int AW = bffa_pkg::WADDR_W;
    localparam int SW = bffa_pkg::SIZE_W;
    localparam int UW = bffa_pkg::UNIT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_MARK_RD, S_MARK_WR, S_DONE
    } t_state;

    t_state                         r_state, n_state;
    bffa_pkg::t_cmd                 r_cmd, n_cmd;
    logic [AW-1:0]                  r_word, n_word;
    logic [SW-1:0]                  r_carry, n_carry;
    logic [UW-1:0]                  r_start, n_start, r_end, n_end;
    logic [bffa_pkg::STAT_W-1:0]    r_stat, n_stat;
    logic [bffa_pkg::NUM_WORDS-1:0] r_vld, n_vld;
    logic                           r_rd_vld;
    logic                           n_out_valid;
    logic [bffa_pkg::STAT_W-1:0]    n_status;
    logic [UW-1:0]                  n_unit_start;

    logic          w_we;
    logic [WW-1:0] w_rdata, w_wd, w_wdata, w_mask, w_low, w_win;
    logic [WW-1:0] w_hit;
    logic          w_hit_any;
    logic [bffa_pkg::BIT_W-1:0] w_hit_idx, w_top_idx, w_lo, w_hi, w_wlo;
    logic [SW:0]   w_sz, w_sum, w_run_start, w_run_end;
    logic [SW-1:0] w_carry_nx;
    logic          w_last_word;

    bffa_ram #(.WIDTH(WW), .DEPTH(bffa_pkg::NUM_WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (r_word),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Words never written since the last clear read as all free.
    assign w_wd = r_rd_vld ? w_rdata : '0;
    assign w_sz = {1'b0, r_cmd.size};
    assign w_last_word = (r_word == AW'(bffa_pkg::NUM_WORDS - 1));

    // Per bit: does a free run of the requested length end here?
    always_comb begin
        w_hit = '0;
        for (int j = 0; j < WW; j++) begin
            w_low = {WW{1'b1}} >> (WW - 1 - j);
            w_wlo = '0;
            w_win = '0;
            if (w_sz <= (SW+1)'(j + 1)) begin
                w_wlo = bffa_pkg::BIT_W'((SW+1)'(j + 1) - w_sz);
                w_win = w_low & ({WW{1'b1}} << w_wlo);
                w_hit[j] = ((w_wd & w_win) == '0);
            end else begin
                w_hit[j] = ((w_wd & w_low) == '0) &&
                           ({1'b0, r_carry} >= (w_sz - (SW+1)'(j + 1)));
            end
        end
        w_hit_any = |w_hit;
        w_hit_idx = '0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (w_hit[j]) begin
                w_hit_idx = bffa_pkg::BIT_W'(j);
            end
        end
        w_top_idx = '0;
        for (int j = 0; j < WW; j++) begin
            if (w_wd[j]) begin
                w_top_idx = bffa_pkg::BIT_W'(j);
            end
        end
        w_sum = {1'b0, r_carry} + (SW+1)'(WW);
        if (w_wd == '0) begin
            w_carry_nx = w_sum[SW] ? {SW{1'b1}} : w_sum[SW-1:0];
        end else begin
            w_carry_nx = SW'(bffa_pkg::BIT_W'(WW - 1) - w_top_idx);
        end
        w_run_start = (SW+1)'({r_word, w_hit_idx}) + (SW+1)'(1) - w_sz;
        w_run_end   = w_run_start + w_sz - (SW+1)'(1);
    end

    // Mask of the run bits that fall in the current word.
    always_comb begin
        w_lo   = (r_word == r_start[UW-1 -: AW]) ? r_start[bffa_pkg::BIT_W-1:0] : '0;
        w_hi   = (r_word == r_end[UW-1 -: AW]) ? r_end[bffa_pkg::BIT_W-1:0] : '1;
        w_mask = ({WW{1'b1}} << w_lo) & ({WW{1'b1}} >> (bffa_pkg::BIT_W'(WW - 1) - w_hi));
        w_wdata = (r_cmd.op == bffa_pkg::OP_ALLOC) ? (w_wd | w_mask) : (w_wd & ~w_mask);
    end

    assign w_we      = (r_state == S_MARK_WR);
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_word       = r_word;
        n_carry      = r_carry;
        n_start      = r_start;
        n_end        = r_end;
        n_stat       = r_stat;
        n_vld        = r_vld;
        n_out_valid  = o_out_valid && !i_out_ready;
        n_status     = o_status;
        n_unit_start = o_unit_start;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_word  = '0;
                    n_carry = '0;
                    n_stat  = i_cmd.status;
                    n_start = '0;
                    unique case (i_cmd.op)
                        bffa_pkg::OP_ALLOC: n_state = S_SCAN_RD;
                        bffa_pkg::OP_FREE: begin
                            n_start = i_cmd.offset;
                            n_end   = UW'({1'b0, i_cmd.offset} + i_cmd.size - SW'(1));
                            n_word  = i_cmd.offset[UW-1 -: AW];
                            n_state = S_MARK_RD;
                        end
                        bffa_pkg::OP_CLEAR: begin
                            n_vld   = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (w_hit_any) begin
                    n_start = UW'(w_run_start);
                    n_end   = UW'(w_run_end);
                    n_word  = w_run_start[UW-1 -: AW];
                    n_state = S_MARK_RD;
                end else if (w_last_word) begin
                    n_stat  = bffa_pkg::ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    n_carry = w_carry_nx;
                    n_word  = r_word + AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: begin
                n_vld[r_word] = 1'b1;
                if (r_word == r_end[UW-1 -: AW]) begin
                    n_state = S_DONE;
                end else begin
                    n_word  = r_word + AW'(1);
                    n_state = S_MARK_RD;
                end
            end
            S_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_status     = r_stat;
                    n_unit_start = (r_cmd.op == bffa_pkg::OP_ALLOC && r_stat == bffa_pkg::ST_OK)
                                   ? r_start : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_word       <= n_word;
        r_carry      <= n_carry;
        r_start      <= n_start;
        r_end        <= n_end;
        r_stat       <= n_stat;
        o_status     <= n_status;
        o_unit_start <= n_unit_start;
        r_rd_vld     <= r_vld[r_word];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            o_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// File: dv/bffa_checker.sv
// Checker for the allocator: watches both channels, predicts results and compares.
`timescale 1ns / 100ps
module bffa_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [bffa_pkg::TYPE_W-1:0] i_req_type,
    input  wire logic [bffa_pkg::UNIT_W-1:0] i_unit_offset,
    input  wire logic [bffa_pkg::SIZE_W-1:0] i_req_size,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [bffa_pkg::STAT_W-1:0] i_status,
    input  wire logic [bffa_pkg::UNIT_W-1:0] i_unit_start,
    output int                               o_fail_count,
    output int                               o_pending
);
    typedef struct packed {
        logic [bffa_pkg::STAT_W-1:0] status;
        logic [bffa_pkg::UNIT_W-1:0] start;
    } t_result;

    logic [bffa_pkg::NUM_UNITS-1:0] unit_busy;
    t_result                        pending_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    function automatic t_result serve_request(input logic [bffa_pkg::TYPE_W-1:0] kind,
                                              input logic [bffa_pkg::UNIT_W-1:0] offset,
                                              input logic [bffa_pkg::SIZE_W-1:0] size);
        t_result r;
        int      run_start;
        int      run_len;
        bit      found;
        r = '0;
        run_start = 0;
        run_len = 0;
        found = 0;
        if (kind == bffa_pkg::REQ_ALLOC) begin
            if (size == 0) begin
                r.status = bffa_pkg::ST_BADSIZE;
            end else begin
                for (int u = 0; u < bffa_pkg::NUM_UNITS && !found; u++) begin
                    if (unit_busy[u]) begin
                        run_len = 0;
                    end else begin
                        if (run_len == 0) run_start = u;
                        run_len++;
                        if (run_len >= int'(size)) found = 1;
                    end
                end
                if (found) begin
                    for (int u = run_start; u < run_start + int'(size); u++)
                        unit_busy[u] = 1'b1;
                    r.start = run_start[bffa_pkg::UNIT_W-1:0];
                    r.status = bffa_pkg::ST_OK;
                end else begin
                    r.status = bffa_pkg::ST_NOSPACE;
                end
            end
        end else if (kind == bffa_pkg::REQ_FREE) begin
            if (size == 0) r.status = bffa_pkg::ST_BADSIZE;
            else if (int'(offset) + int'(size) > bffa_pkg::NUM_UNITS)
                r.status = bffa_pkg::ST_RANGE;
            else for (int u = int'(offset); u < int'(offset) + int'(size); u++)
                unit_busy[u] = 1'b0;
        end else if (kind == bffa_pkg::REQ_CLEAR) begin
            unit_busy = '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            unit_busy = '0;
            pending_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                pending_results.push_back(serve_request(i_req_type, i_unit_offset, i_req_size));
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                    if (i_unit_start !== want.start)
                        report_mismatch("unit_start", int'(i_unit_start), int'(want.start));
                end
            end
        end
        o_pending = pending_results.size();
    end
endmodule

// File: dv/tb_top.sv
// Testbench top: drives requests and result stalls, and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
    // request code with no defined meaning; the block must ignore it
    localparam logic [bffa_pkg::TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [bffa_pkg::TYPE_W-1:0]   i_req_type;
    logic [bffa_pkg::UNIT_W-1:0]   i_unit_offset;
    logic [bffa_pkg::SIZE_W-1:0]   i_req_size;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [bffa_pkg::STAT_W-1:0]   o_status;
    logic [bffa_pkg::UNIT_W-1:0]   o_unit_start;
    int                            fail_count;
    int                            pending;
    // idle rates in percent for each side, changed between phases
    int                            send_idle_pct;
    int                            recv_idle_pct;

    bitmap_first_fit_allocator_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_unit_offset(i_unit_offset),
        .i_req_size   (i_req_size),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_unit_start (o_unit_start)
    );

    bffa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_unit_offset(i_unit_offset),
        .i_req_size   (i_req_size),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (o_status),
        .i_unit_start (o_unit_start),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: pick a fresh ready at every falling edge from the current stall rate.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request, hold it until accepted at a rising edge, then step to
    // the falling edge. Idle gaps are inserted before the item, so back-to-back
    // items keep valid high.
    task automatic send_request(input logic [bffa_pkg::TYPE_W-1:0] kind,
                                input logic [bffa_pkg::UNIT_W-1:0] offset,
                                input logic [bffa_pkg::SIZE_W-1:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_unit_offset <= offset;
        i_req_size    <= size;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Mostly well-formed allocate and free traffic with small sizes; a few
    // huge sizes, zero sizes, out-of-range frees, clears and unknown types.
    task automatic send_random_request();
        int pick;
        logic [bffa_pkg::SIZE_W-1:0] size;
        pick = int'($urandom_range(99));
        if ($urandom_range(19) == 0) size = bffa_pkg::SIZE_W'($urandom_range(8191));
        else if ($urandom_range(9) == 0) size = bffa_pkg::SIZE_W'($urandom_range(4096, 1));
        else size = bffa_pkg::SIZE_W'($urandom_range(64, 1));
        if (pick < 3) size = 0;
        if (pick < 50)
            send_request(bffa_pkg::REQ_ALLOC, bffa_pkg::UNIT_W'($urandom), size);
        else if (pick < 93)
            send_request(bffa_pkg::REQ_FREE, bffa_pkg::UNIT_W'($urandom), size);
        else if (pick < 96)
            send_request(bffa_pkg::REQ_CLEAR, bffa_pkg::UNIT_W'($urandom),
                         bffa_pkg::SIZE_W'($urandom));
        else
            send_request(REQ_UNKNOWN, bffa_pkg::UNIT_W'($urandom),
                         bffa_pkg::SIZE_W'($urandom));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = bffa_pkg::REQ_ALLOC;
        i_unit_offset = '0;
        i_req_size    = '0;
        i_out_ready   = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 59;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero sizes, the extremes, full map, past-the-end frees, clear, unknown
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd0);
        send_request(bffa_pkg::REQ_FREE,  12'd5, 13'd0);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd4097);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd8191);
        send_request(bffa_pkg::REQ_ALLOC, 12'hfff, 13'd1);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd4095);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd1);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd1);
        send_request(bffa_pkg::REQ_FREE,  12'hfff, 13'd2);
        send_request(bffa_pkg::REQ_FREE,  12'hfff, 13'd1);
        send_request(bffa_pkg::REQ_FREE,  12'd0, 13'd8191);
        send_request(bffa_pkg::REQ_FREE,  12'd100, 13'd50);
        send_request(bffa_pkg::REQ_FREE,  12'd100, 13'd50);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd51);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd50);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd1);
        send_request(REQ_UNKNOWN,         12'hfff, 13'h1fff);
        send_request(bffa_pkg::REQ_CLEAR, 12'hfff, 13'h1fff);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd4096);
        send_request(bffa_pkg::REQ_FREE,  12'd0, 13'd4096);
        send_request(bffa_pkg::REQ_ALLOC, 12'd0, 13'd2048);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 11 : 0;
            repeat (610) send_random_request();
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Allow for full scans with long stalls on every item, several times over.
    initial begin
        #400ms;
        $display("tb: failure");
        $finish;
    end
endmodule
